@@ rtl/cda_pkg.sv @@
`default_nettype none

package cda_pkg;

   // Field widths of the date and the request.
   localparam int YEAR_W      = 14;
   localparam int MONTH_W     = 4;
   localparam int DAY_W       = 5;
   localparam int OP_W        = 3;
   localparam int AMOUNT_BITS = 16;

   localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(16383);

   // Operation codes carried in req_tuser.
   localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
   localparam logic [OP_W-1:0] OP_DAYS   = 3'd1;
   localparam logic [OP_W-1:0] OP_MONTHS = 3'd2;
   localparam logic [OP_W-1:0] OP_YEARS  = 3'd3;
   localparam logic [OP_W-1:0] OP_CMP    = 3'd4;

   // Datapath actions issued by the controller.
   localparam int ACT_W = 3;
   localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
   localparam logic [ACT_W-1:0] ACT_LOAD      = 3'd1;
   localparam logic [ACT_W-1:0] ACT_DAY_STEP  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_MON_QUOT  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_MON_SET   = 3'd4;
   localparam logic [ACT_W-1:0] ACT_MON_CLAMP = 3'd5;
   localparam logic [ACT_W-1:0] ACT_YEAR_SET  = 3'd6;
   localparam logic [ACT_W-1:0] ACT_YEAR_FIX  = 3'd7;

   // Month lengths.
   localparam logic [DAY_W-1:0] DAYS_LONG  = 5'd31;
   localparam logic [DAY_W-1:0] DAYS_SHORT = 5'd30;
   localparam logic [DAY_W-1:0] FEB_LEAP   = 5'd29;
   localparam logic [DAY_W-1:0] FEB_COMMON = 5'd28;

   // Request payload layout (tdata), lowest field first.
   localparam int REQ_AMT_LSB   = 0;
   localparam int REQ_YEAR_LSB  = REQ_AMT_LSB + AMOUNT_BITS;
   localparam int REQ_MONTH_LSB = REQ_YEAR_LSB + YEAR_W;
   localparam int REQ_DAY_LSB   = REQ_MONTH_LSB + MONTH_W;
   localparam int REQ_FIELD_W   = REQ_DAY_LSB + DAY_W;
   localparam int REQ_DATA_W    = ((REQ_FIELD_W + 7) / 8) * 8;

   // Response payload layout, lowest field first.
   localparam int RSP_FIELD_W = YEAR_W + MONTH_W + DAY_W + 2 + DAY_W + 3;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // Divisibility by 25 through a reciprocal multiply, exact over the year range.
   localparam int DIV25_SHIFT = YEAR_W + 6;
   localparam int DIV25_W     = DIV25_SHIFT - 4;
   localparam logic [DIV25_W-1:0] DIV25_RECIP = DIV25_W'((2 ** DIV25_SHIFT) / 25 + 1);

   // Month addition: biased month sum divided by 12 through a reciprocal multiply.
   localparam int MON_T_W        = AMOUNT_BITS + 1;
   localparam int MON_SHIFT      = MON_T_W + 4;
   localparam int MON_RECIP_W    = MON_SHIFT - 3;
   localparam logic [MON_RECIP_W-1:0] MON_RECIP = MON_RECIP_W'((2 ** MON_SHIFT) / 12 + 1);
   localparam int MON_QUOT_W     = MON_T_W + MON_RECIP_W - MON_SHIFT;
   localparam int MON_BIAS_YEARS = (2 ** (AMOUNT_BITS - 1)) / 12 + 2;
   localparam int MON_BIAS       = MON_BIAS_YEARS * 12;
   localparam int MON_SUM_W      = ((YEAR_W > MON_QUOT_W) ? YEAR_W : MON_QUOT_W) + 1;

   // Year addition sum, signed.
   localparam int YSUM_W = AMOUNT_BITS + 2;

   // Controller to datapath commands.
   typedef struct packed {
      logic             capture;
      logic [ACT_W-1:0] act;
      logic             emit;
   } cda_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic day_fin;
   } cda_stat_type;

   // Gregorian leap rule: divisible by 4, and not by 100 unless by 400.
   function automatic logic leap_of(input logic [YEAR_W-1:0] y);
      logic [YEAR_W+DIV25_W-1:0] prod;
      logic [YEAR_W-1:0]         q;
      logic [YEAR_W-1:0]         back;
      prod = {{DIV25_W{1'b0}}, y} * {{YEAR_W{1'b0}}, DIV25_RECIP};
      q    = YEAR_W'(prod[YEAR_W+DIV25_W-1:DIV25_SHIFT]);
      back = (q << 4) + (q << 3) + q;
      return (y[1:0] == 2'b00) && ((back != y) || (y[3:0] == 4'b0000));
   endfunction

   // Days in a month; zero for a month outside 1..12.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd4, 4'd6, 4'd9, 4'd11: len = DAYS_SHORT;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAYS_LONG;
         4'd2: len = leap ? FEB_LEAP : FEB_COMMON;
         default: len = '0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

@@ rtl/cda_ctrl.sv @@
`default_nettype none

module cda_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic [cda_pkg::OP_W-1:0]   req_tuser,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output cda_pkg::cda_cmd_type       cmd,
   input  cda_pkg::cda_stat_type      stat
);
   import cda_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_LOAD      = 4'd1;
   localparam logic [3:0] S_DAY       = 4'd2;
   localparam logic [3:0] S_MON_QUOT  = 4'd3;
   localparam logic [3:0] S_MON_SET   = 4'd4;
   localparam logic [3:0] S_MON_CLAMP = 4'd5;
   localparam logic [3:0] S_YEAR_SET  = 4'd6;
   localparam logic [3:0] S_YEAR_FIX  = 4'd7;
   localparam logic [3:0] S_DONE      = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // The output register can take a new result when empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Sequencer: one operation at a time, each as a run of datapath actions.
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.act     = ACT_NONE;
      cmd.emit    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               case (req_tuser)
                  OP_LOAD:   state_in = S_LOAD;
                  OP_DAYS:   state_in = S_DAY;
                  OP_MONTHS: state_in = S_MON_QUOT;
                  OP_YEARS:  state_in = S_YEAR_SET;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_LOAD: begin
            cmd.act  = ACT_LOAD;
            state_in = S_DONE;
         end
         S_DAY: begin
            if (stat.day_fin) begin
               state_in = S_DONE;
            end else begin
               cmd.act = ACT_DAY_STEP;
            end
         end
         S_MON_QUOT: begin
            cmd.act  = ACT_MON_QUOT;
            state_in = S_MON_SET;
         end
         S_MON_SET: begin
            cmd.act  = ACT_MON_SET;
            state_in = S_MON_CLAMP;
         end
         S_MON_CLAMP: begin
            cmd.act  = ACT_MON_CLAMP;
            state_in = S_DONE;
         end
         S_YEAR_SET: begin
            cmd.act  = ACT_YEAR_SET;
            state_in = S_YEAR_FIX;
         end
         S_YEAR_FIX: begin
            cmd.act  = ACT_YEAR_FIX;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Response valid flag: set when a result is written, cleared when taken.
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("accepted transaction did not start an operation");

   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished operation did not load the output register");
`endif

endmodule

`default_nettype wire

@@ rtl/cda_dp.sv @@
`default_nettype none

module cda_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  cda_pkg::cda_cmd_type            cmd,
   output cda_pkg::cda_stat_type           stat,
   input  logic [cda_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [cda_pkg::OP_W-1:0]        req_tuser,
   output logic [cda_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import cda_pkg::*;

   // Held date.
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff, day_in;

   // Captured request.
   logic [OP_W-1:0]        op_ff;
   logic [AMOUNT_BITS-1:0] amt_ff;
   logic [YEAR_W-1:0]      opd_year_ff;
   logic [MONTH_W-1:0]     opd_month_ff;
   logic [DAY_W-1:0]       opd_day_ff;

   // Day stepping.
   logic [AMOUNT_BITS-1:0] rem_ff, rem_in;
   logic                   back_ff;
   logic                   fin_ff, fin_in;

   // Month addition intermediates.
   logic [MON_T_W-1:0]             tsum_ff, tsum_in;
   logic [MON_QUOT_W-1:0]          quot_ff, quot_in;
   logic [MON_T_W+MON_RECIP_W-1:0] mon_prod;

   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Request fields.
   logic [AMOUNT_BITS-1:0] req_amount;
   logic [YEAR_W-1:0]      req_year;
   logic [MONTH_W-1:0]     req_month;
   logic [DAY_W-1:0]       req_day;

   // Calendar facts of the held date.
   logic               leap_cur, leap_inc;
   logic [YEAR_W:0]    year_inc, year_dec;
   logic [DAY_W-1:0]   len_cur;

   // One day-stepping iteration.
   logic [DAY_W-1:0]       room;
   logic                   fits_fwd, fits_bwd;
   logic [AMOUNT_BITS-1:0] cost;
   logic [YEAR_W:0]        fwd_year, bwd_year;
   logic [MONTH_W-1:0]     fwd_month, bwd_month;
   logic                   bwd_leap;
   logic [YEAR_W-1:0]      step_year;
   logic [MONTH_W-1:0]     step_month;
   logic [DAY_W-1:0]       step_day;
   logic [AMOUNT_BITS-1:0] step_rem;
   logic                   step_fin;

   // Month and year addition results.
   logic [MON_T_W-1:0]   q12;
   logic [MON_T_W-1:0]   mrem;
   logic [MON_SUM_W-1:0] usum, ny;
   logic [YEAR_W-1:0]    mon_year;
   logic [MONTH_W-1:0]   mon_month;
   logic [DAY_W-1:0]     clamp_day;
   logic [YSUM_W-1:0]    ysum;
   logic [YEAR_W-1:0]    yadd_year;
   logic [MONTH_W-1:0]   fix_month;
   logic [DAY_W-1:0]     fix_day;

   // Result fields.
   logic date_valid, is_after, is_before, is_equal;
   logic [YEAR_W+MONTH_W+DAY_W-1:0] held_key, opd_key;

   assign req_amount = req_tdata[REQ_AMT_LSB +: AMOUNT_BITS];
   assign req_year   = req_tdata[REQ_YEAR_LSB +: YEAR_W];
   assign req_month  = req_tdata[REQ_MONTH_LSB +: MONTH_W];
   assign req_day    = req_tdata[REQ_DAY_LSB +: DAY_W];

   assign leap_cur = leap_of(year_ff);
   assign year_inc = {1'b0, year_ff} + (YEAR_W+1)'(1);
   assign year_dec = {1'b0, year_ff} - (YEAR_W+1)'(1);
   assign leap_inc = leap_of(year_inc[YEAR_W-1:0]);
   assign len_cur  = month_len(month_ff, leap_cur);

   // Month after and before the held one; months outside 1..12 wrap by month index.
   always_comb begin
      if (month_ff >= 4'd12) begin
         fwd_year  = year_inc;
         fwd_month = month_ff - 4'd11;
      end else begin
         fwd_year  = {1'b0, year_ff};
         fwd_month = month_ff + 4'd1;
      end
      case (month_ff)
         4'd0: begin
            bwd_year  = year_dec;
            bwd_month = 4'd11;
         end
         4'd1: begin
            bwd_year  = year_dec;
            bwd_month = 4'd12;
         end
         4'd14: begin
            bwd_year  = year_inc;
            bwd_month = 4'd1;
         end
         4'd15: begin
            bwd_year  = year_inc;
            bwd_month = 4'd2;
         end
         default: begin
            bwd_year  = {1'b0, year_ff};
            bwd_month = month_ff - 4'd1;
         end
      endcase
      bwd_leap = (month_ff == 4'd15) ? leap_inc : leap_cur;
   end

   // One iteration of day addition: finish inside the month or cross one boundary.
   always_comb begin
      room     = (day_ff < len_cur) ? (len_cur - day_ff) : '0;
      fits_fwd = (day_ff < len_cur) && (rem_ff <= AMOUNT_BITS'(room));
      fits_bwd = (day_ff > 5'd1) && (rem_ff <= AMOUNT_BITS'(day_ff - 5'd1));
      if (back_ff) begin
         cost = (day_ff > 5'd1) ? AMOUNT_BITS'(day_ff) : AMOUNT_BITS'(1);
      end else begin
         cost = AMOUNT_BITS'(room) + AMOUNT_BITS'(1);
      end
      step_rem   = rem_ff - cost;
      step_year  = year_ff;
      step_month = month_ff;
      step_day   = day_ff;
      step_fin   = 1'b1;
      if (!back_ff) begin
         if (fits_fwd) begin
            step_rem = rem_ff;
            step_day = day_ff + DAY_W'(rem_ff);
         end else if (fwd_year[YEAR_W]) begin
            step_year  = YEAR_MAX;
            step_month = 4'd12;
            step_day   = DAYS_LONG;
         end else begin
            step_year  = fwd_year[YEAR_W-1:0];
            step_month = fwd_month;
            step_day   = 5'd1;
            step_fin   = (step_rem == '0);
         end
      end else begin
         if (fits_bwd) begin
            step_rem = rem_ff;
            step_day = day_ff - DAY_W'(rem_ff);
         end else if (year_ff == '0 && month_ff <= 4'd1) begin
            step_year  = '0;
            step_month = 4'd1;
            step_day   = 5'd1;
         end else if (bwd_year[YEAR_W]) begin
            // Past the top year: saturate to the last month of the range.
            step_year  = YEAR_MAX;
            step_month = 4'd12;
            step_day   = DAYS_LONG;
            step_fin   = (step_rem == '0);
         end else begin
            step_year  = bwd_year[YEAR_W-1:0];
            step_month = bwd_month;
            step_day   = month_len(bwd_month, bwd_leap);
            step_fin   = (step_rem == '0);
         end
      end
   end

   // Month addition, first pass: biased month sum taken at capture, then its
   // quotient by 12.
   assign tsum_in  = MON_T_W'(month_ff) + {req_amount[AMOUNT_BITS-1], req_amount}
                   + MON_T_W'(MON_BIAS - 1);
   assign mon_prod = {{MON_RECIP_W{1'b0}}, tsum_ff} * {{MON_T_W{1'b0}}, MON_RECIP};
   assign quot_in  = mon_prod[MON_T_W+MON_RECIP_W-1:MON_SHIFT];

   // Month addition, second pass: remainder gives the month, quotient moves the year.
   always_comb begin
      q12  = (MON_T_W'(quot_ff) << 3) + (MON_T_W'(quot_ff) << 2);
      mrem = tsum_ff - q12;
      usum = MON_SUM_W'(year_ff) + MON_SUM_W'(quot_ff);
      ny   = usum - MON_SUM_W'(MON_BIAS_YEARS);
      if (usum < MON_SUM_W'(MON_BIAS_YEARS)) begin
         mon_year  = '0;
         mon_month = 4'd1;
      end else if (ny > MON_SUM_W'(YEAR_MAX)) begin
         mon_year  = YEAR_MAX;
         mon_month = 4'd12;
      end else begin
         mon_year  = ny[YEAR_W-1:0];
         mon_month = mrem[MONTH_W-1:0] + 4'd1;
      end
   end

   // Pull a late day back to the end of a short month.
   always_comb begin
      clamp_day = day_ff;
      if (day_ff == DAYS_LONG && (month_ff == 4'd4 || month_ff == 4'd6 ||
                                  month_ff == 4'd9 || month_ff == 4'd11)) begin
         clamp_day = DAYS_SHORT;
      end else if (month_ff == 4'd2 && day_ff > FEB_COMMON) begin
         clamp_day = leap_cur ? FEB_LEAP : FEB_COMMON;
      end
   end

   // Year addition with saturation, then Feb 29 to Mar 1 in a common year.
   always_comb begin
      ysum = YSUM_W'(year_ff) + {{2{amt_ff[AMOUNT_BITS-1]}}, amt_ff};
      if (ysum[YSUM_W-1]) begin
         yadd_year = '0;
      end else if (ysum > YSUM_W'(YEAR_MAX)) begin
         yadd_year = YEAR_MAX;
      end else begin
         yadd_year = ysum[YEAR_W-1:0];
      end
      fix_month = month_ff;
      fix_day   = day_ff;
      if (day_ff == FEB_LEAP && month_ff == 4'd2 && !leap_cur) begin
         fix_month = 4'd3;
         fix_day   = 5'd1;
      end
   end

   // Next held date and stepping state.
   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      rem_in   = rem_ff;
      fin_in   = fin_ff;
      case (cmd.act)
         ACT_LOAD: begin
            year_in  = opd_year_ff;
            month_in = opd_month_ff;
            day_in   = opd_day_ff;
         end
         ACT_DAY_STEP: begin
            year_in  = step_year;
            month_in = step_month;
            day_in   = step_day;
            rem_in   = step_rem;
            fin_in   = step_fin;
         end
         ACT_MON_SET: begin
            year_in  = mon_year;
            month_in = mon_month;
         end
         ACT_MON_CLAMP: day_in = clamp_day;
         ACT_YEAR_SET:  year_in = yadd_year;
         ACT_YEAR_FIX: begin
            month_in = fix_month;
            day_in   = fix_day;
         end
         default: ;
      endcase
      if (cmd.capture) begin
         rem_in = req_amount[AMOUNT_BITS-1] ? (AMOUNT_BITS'(0) - req_amount) : req_amount;
         fin_in = (req_amount == '0);
      end
   end

   // Result word built from the held date after the operation.
   always_comb begin
      held_key   = {year_ff, month_ff, day_ff};
      opd_key    = {opd_year_ff, opd_month_ff, opd_day_ff};
      date_valid = (month_ff >= 4'd1) && (month_ff <= 4'd12) && (day_ff != '0) &&
                   (day_ff <= len_cur);
      is_equal   = (op_ff == OP_CMP) && (held_key == opd_key);
      is_after   = (op_ff == OP_CMP) && (opd_year_ff != '0) && (held_key > opd_key);
      is_before  = (op_ff == OP_CMP) && (opd_year_ff != '0) && (held_key < opd_key);
      rsp_data_in = RSP_DATA_W'({is_equal, is_before, is_after, len_cur, leap_cur,
                                 date_valid, day_ff, month_ff, year_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff  <= '0;
         month_ff <= '0;
         day_ff   <= '0;
         fin_ff   <= 1'b1;
      end else begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         fin_ff   <= fin_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (cmd.act == ACT_MON_QUOT) begin
         quot_ff <= quot_in;
      end
      if (cmd.capture) begin
         op_ff        <= req_tuser;
         amt_ff       <= req_amount;
         opd_year_ff  <= req_year;
         opd_month_ff <= req_month;
         opd_day_ff   <= req_day;
         back_ff      <= req_amount[AMOUNT_BITS-1];
         tsum_ff      <= tsum_in;
      end
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign stat.day_fin = fin_ff;
   assign rsp_tdata    = rsp_data_ff;

`ifndef SYNTH
   a_day_step_progress: assert property (@(posedge clock) disable iff (reset)
      (cmd.act == ACT_DAY_STEP && !fin_ff) |=> (fin_ff || rem_ff < $past(rem_ff)))
      else $error("day stepping neither finished nor used up days");

   a_day_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.act == ACT_DAY_STEP && !fin_ff) |=> (day_ff != '0))
      else $error("day stepping left day zero");

   a_month_set_legal: assert property (@(posedge clock) disable iff (reset)
      (cmd.act == ACT_MON_SET) |=> (month_ff >= 4'd1 && month_ff <= 4'd12))
      else $error("month addition produced an illegal month");
`endif

endmodule

`default_nettype wire

@@ rtl/calendar_date_arithmetic_top.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  req_tuser: op; req_tdata: operands
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata: held date, flags, compare
//
// Compare and unused codes go straight to the result; a load copies the operands; a
// year add sets the year, then fixes Feb 29; a month add divides by 12, sets year
// and month, then clamps the day; a day add crosses a month boundary per step
// until the days run out or the date saturates. One operation runs at a time. A new
// transaction is taken once the previous result sits in the output register, even
// while rsp_tready is low. Reset is synchronous and clears the held date to zero.
`default_nettype none

module calendar_date_arithmetic_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: amount[15:0], in_year[29:16], in_month[33:30], in_day[38:34], zero pad
   input  logic [cda_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: op[2:0]
   input  logic [cda_pkg::OP_W-1:0]        req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: out_year[13:0], out_month[17:14], out_day[22:18], date_valid[23],
   // leap_year[24], month_length[29:25], is_after[30], is_before[31],
   // is_equal[32], zero pad
   output logic [cda_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import cda_pkg::*;

   cda_cmd_type  cmd;
   cda_stat_type stat;

   // Operation sequencer and response handshake.
   cda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // Held date, arithmetic units and output register.
   cda_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire
